@@ hdl/lpcm_pkg.sv @@
// ----------------------------------------------------------------------------
// Closest-midpoint package
// Shared widths, defaults and types of the line pair closest-midpoint unit.
// ----------------------------------------------------------------------------
package lpcm_pkg;

  // Default widths of the point coordinates and of the Q1.x directions.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int DIR_WIDTH_DEF   = 16;

  // Result word width and fraction bits of the line parameters.
  localparam int RES_W      = 32;
  localparam int PARAM_FRAC = 15;

  // Parallel test shift register.
  localparam int TOL_W = 6;

  typedef logic signed [RES_W-1:0] res_t;
  typedef logic [TOL_W-1:0]        tol_t;

  // Reset value of the tolerance shift, about 1e-14 relative tolerance.
  localparam tol_t TOL_SHIFT_RESET = tol_t'(46);

endpackage

@@ hdl/lpcm_dly.sv @@
// ----------------------------------------------------------------------------
// Delay line
// Fixed-depth register chain that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module lpcm_dly #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_q [N];

  always_ff @(posedge clk) begin
    tap_q[0] <= d;
    for (int i = 1; i < N; i++) begin
      tap_q[i] <= tap_q[i-1];
    end
  end

  assign q = tap_q[N-1];

endmodule

@@ hdl/lpcm_mul.sv @@
// ----------------------------------------------------------------------------
// Pipelined multiplier
// Signed a times signed b, b cut into chunks, one partial product per stage.
// ----------------------------------------------------------------------------
module lpcm_mul #(
  parameter int AW     = 34,
  parameter int BW     = 51,
  parameter int STAGES = 2
) (
  input  logic                      clk,
  input  logic signed [AW-1:0]      a,
  input  logic signed [BW-1:0]      b,
  output logic signed [AW+BW-1:0]   p
);

  localparam int CW = (BW + STAGES - 1) / STAGES;
  localparam int XW = CW * STAGES;
  localparam int PW = AW + BW;

  logic signed [XW-1:0]   b_x;
  logic signed [AW-1:0]   a_in   [STAGES];
  logic signed [AW-1:0]   a_q    [STAGES];
  logic signed [XW-1:0]   b_in   [STAGES];
  logic signed [XW-1:0]   b_q    [STAGES];
  logic signed [PW-1:0]   acc_in [STAGES];
  logic signed [PW-1:0]   acc_q  [STAGES];
  logic signed [CW:0]     chunk  [STAGES];
  logic signed [AW+CW:0]  pp     [STAGES];

  assign b_x = XW'(b);

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    if (s == 0) begin : g_head
      assign a_in[s]   = a;
      assign b_in[s]   = b_x;
      assign acc_in[s] = '0;
    end else begin : g_body
      assign a_in[s]   = a_q[s-1];
      assign b_in[s]   = b_q[s-1];
      assign acc_in[s] = acc_q[s-1];
    end

    // Only the top chunk carries the sign of b.
    if (s == STAGES - 1) begin : g_top
      assign chunk[s] = $signed({b_in[s][XW-1], b_in[s][s*CW +: CW]});
    end else begin : g_low
      assign chunk[s] = $signed({1'b0, b_in[s][s*CW +: CW]});
    end

    assign pp[s] = a_in[s] * chunk[s];

    always_ff @(posedge clk) begin
      a_q[s]   <= a_in[s];
      b_q[s]   <= b_in[s];
      acc_q[s] <= acc_in[s] + (PW'(pp[s]) <<< (s * CW));
    end
  end

  assign p = acc_q[STAGES-1];

endmodule

@@ hdl/lpcm_div.sv @@
// ----------------------------------------------------------------------------
// Rounding divider
// Pipelined restoring divider: signed num over positive den, rounded to
// nearest with ties away from zero, saturated to the result width.
// ----------------------------------------------------------------------------
module lpcm_div #(
  parameter int NUMW = 104,
  parameter int DENW = 69
) (
  input  logic                   clk,
  input  logic signed [NUMW-1:0] num,
  input  logic [DENW-1:0]        den,
  output lpcm_pkg::res_t         quo
);

  import lpcm_pkg::*;

  localparam int QW  = RES_W;
  localparam int NW  = NUMW + 2;
  localparam int DDW = DENW + 1;
  localparam int W   = (NW > DDW + QW) ? NW : DDW + QW;
  localparam logic [QW-1:0] NEG_LIM = QW'(1) << (QW - 1);
  localparam logic [QW-1:0] POS_LIM = NEG_LIM - QW'(1);

  logic [NUMW-1:0] mag;
  logic [NW-1:0]   n_q;
  logic [DDW-1:0]  dd_q;
  logic            neg_q;
  logic            big;

  logic [W-1:0]  rem_q  [QW+1];
  logic [W-1:0]  dw_q   [QW+1];
  logic [QW-1:0] qb_q   [QW+1];
  logic          neg_s  [QW+1];
  logic          big_s  [QW+1];
  logic [W-1:0]  sh     [QW];
  logic          ge     [QW];

  logic [QW-1:0] q_fin;
  logic          over;

  // Rounding is folded in: q = (2|num| + den) / (2 den).
  assign mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);

  always_ff @(posedge clk) begin
    n_q   <= (NW'(mag) << 1) + NW'(den);
    dd_q  <= DDW'(den) << 1;
    neg_q <= num[NUMW-1];
  end

  assign big = W'(n_q) >= (W'(dd_q) << QW);

  always_ff @(posedge clk) begin
    rem_q[0] <= W'(n_q);
    dw_q[0]  <= W'(dd_q);
    qb_q[0]  <= '0;
    neg_s[0] <= neg_q;
    big_s[0] <= big;
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    assign sh[i] = dw_q[i] << (QW - 1 - i);
    assign ge[i] = rem_q[i] >= sh[i];

    always_ff @(posedge clk) begin
      rem_q[i+1] <= ge[i] ? rem_q[i] - sh[i] : rem_q[i];
      dw_q[i+1]  <= dw_q[i];
      qb_q[i+1]  <= {qb_q[i][QW-2:0], ge[i]};
      neg_s[i+1] <= neg_s[i];
      big_s[i+1] <= big_s[i];
    end
  end

  assign q_fin = qb_q[QW];
  assign over  = big_s[QW] || (neg_s[QW] ? (q_fin > NEG_LIM) : (q_fin > POS_LIM));

  always_ff @(posedge clk) begin
    if (over) begin
      quo <= neg_s[QW] ? res_t'(NEG_LIM) : res_t'(POS_LIM);
    end else begin
      quo <= neg_s[QW] ? res_t'(-q_fin) : res_t'(q_fin);
    end
  end

endmodule

@@ hdl/line_pair_closest_midpoint_unit.sv @@
// ----------------------------------------------------------------------------
// Line pair closest-midpoint unit
// An item taken at a rising edge passes through 46 register stages; its result
// is then on the result ports with done high.
// Throughput: one item per cycle; busy stays low, so start is never held off.
// Depth is set by the restoring dividers and the chunked multipliers.
// Reset clears the valid chain and loads tolerance_shift with 46.
// ----------------------------------------------------------------------------
//
// Each item is two 3D lines, point plus direction. The pipeline forms
//   w = p1 - p2, k1 = w.d1, k2 = w.d2, a11 = d1.d2, n1 = d1.d1, n2 = d2.d2,
//   den = n1*n2 - a11^2, mag = n1*n2 + a11^2,
//   t1 = a11*k2 - n2*k1, t2 = n1*k2 - a11*k1,
// all exact. The pair counts as parallel when den is zero or when
// |den| shifted left by tolerance_shift is below mag; that transaction then
// returns zeros with status set. Otherwise five rounding dividers produce
//   mid = ((p1+p2)*den + d1*t1 + d2*t2) / (2*den) per axis, and
//   param = (t << (DIR_WIDTH-1+15)) / den for both lines.
//
// Stage map (stages numbered in order from the accept):
//   1      w and p1+p2, directions registered
//   2      per-axis products
//   3      dot products summed
//   4..5   a11^2, n1*n2 and the four t terms (two-stage multipliers)
//   6      den, mag, t1, t2
//   7      parallel flag (then delayed to the output)
//   7..9   (p1+p2)*den, d*t products (three-stage multipliers)
//   10     midpoint numerators
//   11..45 dividers
//   46     output register
// Nothing in the pipeline stalls; the receiver takes every result.
// The configuration channel is always ready; the user must change the register
// only while no transaction is in flight, as the block does not enforce it.
module line_pair_closest_midpoint_unit #(
  parameter int COORD_WIDTH = lpcm_pkg::COORD_WIDTH_DEF,
  parameter int DIR_WIDTH   = lpcm_pkg::DIR_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] first_px,
  input  logic signed [COORD_WIDTH-1:0] first_py,
  input  logic signed [COORD_WIDTH-1:0] first_pz,
  input  logic signed [DIR_WIDTH-1:0]   first_dx,
  input  logic signed [DIR_WIDTH-1:0]   first_dy,
  input  logic signed [DIR_WIDTH-1:0]   first_dz,
  input  logic signed [COORD_WIDTH-1:0] second_px,
  input  logic signed [COORD_WIDTH-1:0] second_py,
  input  logic signed [COORD_WIDTH-1:0] second_pz,
  input  logic signed [DIR_WIDTH-1:0]   second_dx,
  input  logic signed [DIR_WIDTH-1:0]   second_dy,
  input  logic signed [DIR_WIDTH-1:0]   second_dz,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  lpcm_pkg::tol_t                cfg_data,
  output logic                          done,
  output lpcm_pkg::res_t                mid_x,
  output lpcm_pkg::res_t                mid_y,
  output lpcm_pkg::res_t                mid_z,
  output lpcm_pkg::res_t                param_first,
  output lpcm_pkg::res_t                param_second,
  output logic                          status
);

  import lpcm_pkg::*;

  // Pipeline geometry.
  localparam int M1_ST   = 2;
  localparam int M2_ST   = 3;
  localparam int DIV_LAT = RES_W + 3;
  localparam int LAT     = 3 + M1_ST + 1 + M2_ST + 1 + DIV_LAT + 1;
  localparam int PD_DLY  = 2 + M1_ST + 1;
  localparam int TD_DLY  = M2_ST + 1;
  localparam int FL_DLY  = M2_ST + DIV_LAT;

  // Exact word widths.
  localparam int DWW  = COORD_WIDTH + 1;
  localparam int PKW  = DWW + DIR_WIDTH;
  localparam int KW   = COORD_WIDTH + DIR_WIDTH + 3;
  localparam int PDW  = 2 * DIR_WIDTH;
  localparam int AW2  = 2 * DIR_WIDTH + 2;
  localparam int SQW  = 2 * AW2;
  localparam int TPW  = AW2 + KW;
  localparam int DENW = SQW + 1;
  localparam int TW   = TPW + 1;
  localparam int MPW  = DWW + DENW;
  localparam int MW   = MPW + 2;
  localparam int PSH  = DIR_WIDTH - 1 + PARAM_FRAC;
  localparam int PNW  = TW + PSH;
  localparam int SHW  = DENW + (2 ** TOL_W) - 1;
  localparam int PDLW = 3 * DWW + 6 * DIR_WIDTH;
  localparam int TDLW = 2 * TW + DENW;

  // ---------------------------------------------------------------------------
  // Handshake and configuration
  // ---------------------------------------------------------------------------
  logic         accept;
  logic [LAT-1:0] vld_q;
  tol_t         tolerance_shift;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance_shift <= TOL_SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tolerance_shift <= cfg_data;
    end
  end

  // Valid bits follow the data down the pipe.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  assign done = vld_q[LAT-1];

  // ---------------------------------------------------------------------------
  // Stage 1: differences and sums of the points
  // ---------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] p1 [3];
  logic signed [COORD_WIDTH-1:0] p2 [3];
  logic signed [DIR_WIDTH-1:0]   d1 [3];
  logic signed [DIR_WIDTH-1:0]   d2 [3];

  assign p1[0] = first_px;
  assign p1[1] = first_py;
  assign p1[2] = first_pz;
  assign p2[0] = second_px;
  assign p2[1] = second_py;
  assign p2[2] = second_pz;
  assign d1[0] = first_dx;
  assign d1[1] = first_dy;
  assign d1[2] = first_dz;
  assign d2[0] = second_dx;
  assign d2[1] = second_dy;
  assign d2[2] = second_dz;

  logic signed [DWW-1:0]       dw_q [3];
  logic signed [DWW-1:0]       ps_q [3];
  logic signed [DIR_WIDTH-1:0] d1_q [3];
  logic signed [DIR_WIDTH-1:0] d2_q [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dw_q[i] <= DWW'(p1[i]) - DWW'(p2[i]);
      ps_q[i] <= DWW'(p1[i]) + DWW'(p2[i]);
      d1_q[i] <= d1[i];
      d2_q[i] <= d2[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: per-axis products
  // ---------------------------------------------------------------------------
  logic signed [PKW-1:0] pk1_q [3];
  logic signed [PKW-1:0] pk2_q [3];
  logic signed [PDW-1:0] pa_q  [3];
  logic signed [PDW-1:0] pn1_q [3];
  logic signed [PDW-1:0] pn2_q [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pk1_q[i] <= PKW'(dw_q[i]) * PKW'(d1_q[i]);
      pk2_q[i] <= PKW'(dw_q[i]) * PKW'(d2_q[i]);
      pa_q[i]  <= PDW'(d1_q[i]) * PDW'(d2_q[i]);
      pn1_q[i] <= PDW'(d1_q[i]) * PDW'(d1_q[i]);
      pn2_q[i] <= PDW'(d2_q[i]) * PDW'(d2_q[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: dot products
  // ---------------------------------------------------------------------------
  logic signed [KW-1:0]  k1_q;
  logic signed [KW-1:0]  k2_q;
  logic signed [AW2-1:0] a11_q;
  logic signed [AW2-1:0] n1_q;
  logic signed [AW2-1:0] n2_q;

  always_ff @(posedge clk) begin
    k1_q  <= KW'(pk1_q[0]) + KW'(pk1_q[1]) + KW'(pk1_q[2]);
    k2_q  <= KW'(pk2_q[0]) + KW'(pk2_q[1]) + KW'(pk2_q[2]);
    a11_q <= AW2'(pa_q[0]) + AW2'(pa_q[1]) + AW2'(pa_q[2]);
    n1_q  <= AW2'(pn1_q[0]) + AW2'(pn1_q[1]) + AW2'(pn1_q[2]);
    n2_q  <= AW2'(pn2_q[0]) + AW2'(pn2_q[1]) + AW2'(pn2_q[2]);
  end

  // ---------------------------------------------------------------------------
  // Stages 4 and 5: second-order products
  // ---------------------------------------------------------------------------
  logic signed [SQW-1:0] sq;
  logic signed [SQW-1:0] nn;
  logic signed [TPW-1:0] ak2;
  logic signed [TPW-1:0] nk1;
  logic signed [TPW-1:0] nk2;
  logic signed [TPW-1:0] ak1;

  lpcm_mul #(.AW(AW2), .BW(AW2), .STAGES(M1_ST)) u_mul_sq (
    .clk (clk), .a (a11_q), .b (a11_q), .p (sq)
  );
  lpcm_mul #(.AW(AW2), .BW(AW2), .STAGES(M1_ST)) u_mul_nn (
    .clk (clk), .a (n1_q), .b (n2_q), .p (nn)
  );
  lpcm_mul #(.AW(AW2), .BW(KW), .STAGES(M1_ST)) u_mul_ak2 (
    .clk (clk), .a (a11_q), .b (k2_q), .p (ak2)
  );
  lpcm_mul #(.AW(AW2), .BW(KW), .STAGES(M1_ST)) u_mul_nk1 (
    .clk (clk), .a (n2_q), .b (k1_q), .p (nk1)
  );
  lpcm_mul #(.AW(AW2), .BW(KW), .STAGES(M1_ST)) u_mul_nk2 (
    .clk (clk), .a (n1_q), .b (k2_q), .p (nk2)
  );
  lpcm_mul #(.AW(AW2), .BW(KW), .STAGES(M1_ST)) u_mul_ak1 (
    .clk (clk), .a (a11_q), .b (k1_q), .p (ak1)
  );

  // ---------------------------------------------------------------------------
  // Stage 6: determinant, magnitude sum and both parameter numerators
  // ---------------------------------------------------------------------------
  logic signed [DENW-1:0] den_q;
  logic signed [DENW-1:0] mag_q;
  logic signed [TW-1:0]   t1_q;
  logic signed [TW-1:0]   t2_q;

  always_ff @(posedge clk) begin
    den_q <= DENW'(nn) - DENW'(sq);
    mag_q <= DENW'(sq) + DENW'(nn);
    t1_q  <= TW'(ak2) - TW'(nk1);
    t2_q  <= TW'(nk2) - TW'(ak1);
  end

  // Points and directions delayed to meet den and t at stage 6.
  logic [PDLW-1:0]             pd_in;
  logic [PDLW-1:0]             pd_out;
  logic signed [DWW-1:0]       ps_d [3];
  logic signed [DIR_WIDTH-1:0] d1_d [3];
  logic signed [DIR_WIDTH-1:0] d2_d [3];

  assign pd_in = {ps_q[0], ps_q[1], ps_q[2],
                  d1_q[0], d1_q[1], d1_q[2],
                  d2_q[0], d2_q[1], d2_q[2]};

  lpcm_dly #(.W(PDLW), .N(PD_DLY)) u_dly_pd (
    .clk (clk), .d (pd_in), .q (pd_out)
  );

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign ps_d[i] = $signed(pd_out[PDLW-1-i*DWW -: DWW]);
    assign d1_d[i] = $signed(pd_out[6*DIR_WIDTH-1-i*DIR_WIDTH -: DIR_WIDTH]);
    assign d2_d[i] = $signed(pd_out[3*DIR_WIDTH-1-i*DIR_WIDTH -: DIR_WIDTH]);
  end

  // ---------------------------------------------------------------------------
  // Stage 7: parallel test
  // ---------------------------------------------------------------------------
  logic [DENW-1:0] abs_den;
  logic [SHW-1:0]  den_sh;
  logic            par_q;
  logic            par_d;

  assign abs_den = den_q[DENW-1] ? DENW'(-den_q) : DENW'(den_q);
  assign den_sh  = SHW'(abs_den) << tolerance_shift;

  always_ff @(posedge clk) begin
    par_q <= (den_q == '0) || (den_sh < SHW'($unsigned(mag_q)));
  end

  lpcm_dly #(.W(1), .N(FL_DLY)) u_dly_par (
    .clk (clk), .d (par_q), .q (par_d)
  );

  // ---------------------------------------------------------------------------
  // Stages 7 to 10: midpoint numerators
  // ---------------------------------------------------------------------------
  logic signed [MPW-1:0] pden [3];
  logic signed [MPW-1:0] pt1  [3];
  logic signed [MPW-1:0] pt2  [3];
  logic signed [MW-1:0]  m_q  [3];

  for (genvar i = 0; i < 3; i++) begin : g_axis
    lpcm_mul #(.AW(DWW), .BW(DENW), .STAGES(M2_ST)) u_mul_pden (
      .clk (clk), .a (ps_d[i]), .b (den_q), .p (pden[i])
    );
    lpcm_mul #(.AW(DIR_WIDTH), .BW(TW), .STAGES(M2_ST)) u_mul_pt1 (
      .clk (clk), .a (d1_d[i]), .b (t1_q), .p (pt1[i])
    );
    lpcm_mul #(.AW(DIR_WIDTH), .BW(TW), .STAGES(M2_ST)) u_mul_pt2 (
      .clk (clk), .a (d2_d[i]), .b (t2_q), .p (pt2[i])
    );

    always_ff @(posedge clk) begin
      m_q[i] <= MW'(pden[i]) + MW'(pt1[i]) + MW'(pt2[i]);
    end
  end

  // t1, t2 and den delayed to meet the midpoint numerators.
  logic [TDLW-1:0]        td_out;
  logic signed [TW-1:0]   t1_d;
  logic signed [TW-1:0]   t2_d;
  logic [DENW-2:0]        den_d;

  lpcm_dly #(.W(TDLW), .N(TD_DLY)) u_dly_td (
    .clk (clk), .d ({t1_q, t2_q, den_q}), .q (td_out)
  );

  assign t1_d  = $signed(td_out[TDLW-1 -: TW]);
  assign t2_d  = $signed(td_out[DENW+TW-1 -: TW]);
  // den is never negative (Cauchy-Schwarz), so its sign bit is dropped.
  assign den_d = td_out[DENW-2:0];

  // ---------------------------------------------------------------------------
  // Stages 11 to 45: rounding dividers
  // ---------------------------------------------------------------------------
  logic signed [PNW-1:0] pn1;
  logic signed [PNW-1:0] pn2;
  logic [DENW-1:0]       den2;
  res_t                  q_mid [3];
  res_t                  q_t1;
  res_t                  q_t2;

  assign pn1  = PNW'(t1_d) <<< PSH;
  assign pn2  = PNW'(t2_d) <<< PSH;
  assign den2 = {den_d, 1'b0};

  for (genvar i = 0; i < 3; i++) begin : g_div
    lpcm_div #(.NUMW(MW), .DENW(DENW)) u_div_mid (
      .clk (clk), .num (m_q[i]), .den (den2), .quo (q_mid[i])
    );
  end

  lpcm_div #(.NUMW(PNW), .DENW(DENW-1)) u_div_t1 (
    .clk (clk), .num (pn1), .den (den_d), .quo (q_t1)
  );
  lpcm_div #(.NUMW(PNW), .DENW(DENW-1)) u_div_t2 (
    .clk (clk), .num (pn2), .den (den_d), .quo (q_t2)
  );

  // ---------------------------------------------------------------------------
  // Stage 46: output register; a parallel pair returns zeros with status set.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (par_d) begin
      mid_x        <= '0;
      mid_y        <= '0;
      mid_z        <= '0;
      param_first  <= '0;
      param_second <= '0;
      status       <= 1'b1;
    end else begin
      mid_x        <= q_mid[0];
      mid_y        <= q_mid[1];
      mid_z        <= q_mid[2];
      param_first  <= q_t1;
      param_second <= q_t2;
      status       <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Every result strobe traces back through the valid chain to an accepted transaction.
  a_done_origin : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result strobe without a matching accepted transaction");

  // A parallel result carries all-zero fields.
  a_parallel_zero : assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (mid_x == '0 && mid_y == '0 && mid_z == '0 &&
                          param_first == '0 && param_second == '0))
    else $error("parallel result with nonzero fields");

  // A configuration write lands in the tolerance register.
  a_cfg_write : assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (tolerance_shift == $past(cfg_data)))
    else $error("tolerance shift not updated by configuration write");

endmodule

@@ verif/lpcm_checker.sv @@
// ----------------------------------------------------------------------------
// Closest-midpoint checker
// Watches the input, configuration and result channels of the line pair
// closest-midpoint unit. It predicts each result with exact wide-integer
// arithmetic and compares it with what the unit returns.
// ----------------------------------------------------------------------------
module lpcm_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic signed [31:0]    first_px,
  input  logic signed [31:0]    first_py,
  input  logic signed [31:0]    first_pz,
  input  logic signed [15:0]    first_dx,
  input  logic signed [15:0]    first_dy,
  input  logic signed [15:0]    first_dz,
  input  logic signed [31:0]    second_px,
  input  logic signed [31:0]    second_py,
  input  logic signed [31:0]    second_pz,
  input  logic signed [15:0]    second_dx,
  input  logic signed [15:0]    second_dy,
  input  logic signed [15:0]    second_dz,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  lpcm_pkg::tol_t        cfg_data,
  input  logic                  done,
  input  lpcm_pkg::res_t        mid_x,
  input  lpcm_pkg::res_t        mid_y,
  input  lpcm_pkg::res_t        mid_z,
  input  lpcm_pkg::res_t        param_first,
  input  lpcm_pkg::res_t        param_second,
  input  logic                  status,
  output int                    fail_count,
  output int                    pending_count
);
  import lpcm_pkg::*;

  localparam logic ST_CROSSING = 1'b0;
  localparam logic ST_PARALLEL = 1'b1;
  localparam int   PARAM_SHIFT = 16 - 1 + PARAM_FRAC;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    res_t mx, my, mz, t_first, t_second;
    logic st;
  } closest_t;

  closest_t closest_q[$];
  tol_t     tol_shift;

  // Rounds num/dv to nearest with ties away from zero, saturating to 32 bits.
  function automatic res_t div_round_sat(input wide_t num, input wide_t dv);
    wide_t n, d, q;
    logic  neg;
    n = num;
    d = dv;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    if (d == 0) return '0;
    neg = n < 0;
    if (neg) n = -n;
    q = (2 * n + d) / (2 * d);
    if (neg) begin
      if (q > wide_t'(64'sd2147483648)) return res_t'(32'h8000_0000);
      return res_t'(-q);
    end
    if (q > wide_t'(64'sd2147483647)) return res_t'(32'h7fff_ffff);
    return res_t'(q);
  endfunction

  function automatic closest_t predict_closest(input tol_t sh);
    wide_t    p1[3], p2[3], d1[3], d2[3];
    wide_t    k1, k2, a11, n1, n2, sq, nn, den, mag, t1, t2, m, aden;
    closest_t r;
    p1 = '{wide_t'(first_px), wide_t'(first_py), wide_t'(first_pz)};
    p2 = '{wide_t'(second_px), wide_t'(second_py), wide_t'(second_pz)};
    d1 = '{wide_t'(first_dx), wide_t'(first_dy), wide_t'(first_dz)};
    d2 = '{wide_t'(second_dx), wide_t'(second_dy), wide_t'(second_dz)};
    k1 = 0; k2 = 0; a11 = 0; n1 = 0; n2 = 0;
    for (int i = 0; i < 3; i++) begin
      k1  += (p1[i] - p2[i]) * d1[i];
      k2  += (p1[i] - p2[i]) * d2[i];
      a11 += d1[i] * d2[i];
      n1  += d1[i] * d1[i];
      n2  += d2[i] * d2[i];
    end
    sq   = a11 * a11;
    nn   = n1 * n2;
    den  = nn - sq;
    mag  = sq + nn;
    aden = (den < 0) ? -den : den;
    r    = '0;
    if (den == 0 || (aden << sh) < mag) begin
      r.st = ST_PARALLEL;
      return r;
    end
    t1 = a11 * k2 - n2 * k1;
    t2 = n1 * k2 - a11 * k1;
    for (int i = 0; i < 3; i++) begin
      m = (p1[i] + p2[i]) * den + d1[i] * t1 + d2[i] * t2;
      case (i)
        0: r.mx = div_round_sat(m, den << 1);
        1: r.my = div_round_sat(m, den << 1);
        default: r.mz = div_round_sat(m, den << 1);
      endcase
    end
    r.t_first  = div_round_sat(t1 << PARAM_SHIFT, den);
    r.t_second = div_round_sat(t2 << PARAM_SHIFT, den);
    r.st       = ST_CROSSING;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    closest_t exp_r;
    if (rst) begin
      tol_shift     <= TOL_SHIFT_RESET;
      fail_count    = 0;
      pending_count = 0;
      closest_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) tol_shift <= cfg_data;
      if (start && !busy) closest_q.push_back(predict_closest(tol_shift));
      if (done) begin
        if (closest_q.size() == 0) begin
          $error("result with no transaction outstanding");
          fail_count++;
        end else begin
          exp_r = closest_q.pop_front();
          check_field("mid_x", exp_r.mx, mid_x);
          check_field("mid_y", exp_r.my, mid_y);
          check_field("mid_z", exp_r.mz, mid_z);
          check_field("param_first", exp_r.t_first, param_first);
          check_field("param_second", exp_r.t_second, param_second);
          check_field("status", 32'(exp_r.st), 32'(status));
        end
      end
      pending_count = closest_q.size();
    end
  end

endmodule

@@ verif/tb_line_pair_closest_midpoint_unit.sv @@
// ----------------------------------------------------------------------------
// Closest-midpoint unit testbench
// Drives line pairs into the unit in random bursts under several tolerance
// settings, while a checker beside the unit predicts and compares results.
// ----------------------------------------------------------------------------
module tb_line_pair_closest_midpoint_unit;
  import lpcm_pkg::*;

  // Idle limit after which the watchdog ends the run for lack of progress.
  localparam int IDLE_LIMIT = 2000;
  // The unit has 46 register stages; this covers its drain time.
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic signed [31:0] p1[3];
    logic signed [31:0] p2[3];
    logic signed [15:0] d1[3];
    logic signed [15:0] d2[3];
  } line_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] first_px = '0, first_py = '0, first_pz = '0;
  logic signed [15:0] first_dx = '0, first_dy = '0, first_dz = '0;
  logic signed [31:0] second_px = '0, second_py = '0, second_pz = '0;
  logic signed [15:0] second_dx = '0, second_dy = '0, second_dz = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  tol_t cfg_data = '0;
  logic done;
  res_t mid_x, mid_y, mid_z, param_first, param_second;
  logic status;
  int   fail_count, pending_count;
  int   burst_left = 0;
  int   idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  line_pair_closest_midpoint_unit DUT (.*);
  lpcm_checker u_checker (.*);

  // Watchdog: any accepted transaction, result or register write counts as
  // progress. A hang here would otherwise stall the run forever.
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[line_pair_closest_midpoint_unit] ERROR");
      $finish;
    end
  end

  // Sends one line pair. The sender works in bursts; when a burst runs out,
  // start drops for a random gap so that idle cycles land on every pipeline
  // phase. Back-to-back items keep start high with a single assignment.
  task automatic send_pair(input line_pair_t lp);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 20);
    end
    start     <= 1'b1;
    first_px  <= lp.p1[0]; first_py  <= lp.p1[1]; first_pz  <= lp.p1[2];
    first_dx  <= lp.d1[0]; first_dy  <= lp.d1[1]; first_dz  <= lp.d1[2];
    second_px <= lp.p2[0]; second_py <= lp.p2[1]; second_pz <= lp.p2[2];
    second_dx <= lp.d2[0]; second_dy <= lp.d2[1]; second_dz <= lp.d2[2];
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
  endtask

  // Stops sending and waits for every outstanding transaction to return,
  // then lets the pipeline run empty before anything else happens.
  task automatic drain_pipeline();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(input tol_t value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random pair. Most are full range; some use small coordinates, and some
  // derive each axis of the second direction from the first (small offset,
  // sign flip or shift), which exercises the tolerance test and saturation.
  function automatic line_pair_t random_pair();
    line_pair_t lp;
    int         kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      lp.p1[i] = $urandom;
      lp.p2[i] = $urandom;
      lp.d1[i] = 16'($urandom);
      lp.d2[i] = 16'($urandom);
      if (kind >= 4 && kind <= 6) begin
        lp.p1[i] = $signed(32'($urandom_range(0, 2000))) - 1000;
        lp.p2[i] = $signed(32'($urandom_range(0, 2000))) - 1000;
      end
      if (kind == 7) lp.d2[i] = lp.d1[i] + 16'($urandom_range(0, 8)) - 16'sd4;
      if (kind == 8) lp.d2[i] = ($urandom_range(0, 1) != 0) ? -lp.d1[i] : lp.d1[i];
      if (kind == 9) lp.d2[i] = lp.d1[i] >>> $urandom_range(0, 3);
    end
    return lp;
  endfunction

  function automatic line_pair_t make_pair(input int px1, py1, pz1,
                                            input int dx1, dy1, dz1,
                                            input int px2, py2, pz2,
                                            input int dx2, dy2, dz2);
    line_pair_t lp;
    lp.p1 = '{px1, py1, pz1};
    lp.d1 = '{16'(dx1), 16'(dy1), 16'(dz1)};
    lp.p2 = '{px2, py2, pz2};
    lp.d2 = '{16'(dx2), 16'(dy2), 16'(dz2)};
    return lp;
  endfunction

  initial begin
    tol_t tol_plan[5];
    int   min_i, max_i;
    min_i = 32'h8000_0000;
    max_i = 32'h7fff_ffff;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cases under the reset tolerance.
    // All zero: degenerate, both directions vanish.
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // One zero direction.
    send_pair(make_pair(5, 6, 7, 32767, 0, 0, 1, 2, 3, 0, 0, 0));
    // Axis lines crossing at a point.
    send_pair(make_pair(-100, 0, 0, 32767, 0, 0, 0, 50, 0, 0, -32768, 0));
    // Skew lines, offset along z.
    send_pair(make_pair(10, 20, 300, 32767, 0, 0, 10, 20, -300, 0, 32767, 0));
    // Exactly parallel and antiparallel.
    send_pair(make_pair(1, 2, 3, 1000, 2000, 3000, 7, 8, 9, 1000, 2000, 3000));
    send_pair(make_pair(1, 2, 3, 100, -200, 300, 7, 8, 9, -100, 200, -300));
    // Coordinate extremes with extreme directions.
    send_pair(make_pair(max_i, max_i, max_i, 32767, 32767, 32767,
                        min_i, min_i, min_i, -32768, 32767, -32768));
    send_pair(make_pair(min_i, max_i, min_i, -32768, -32768, -32768,
                        max_i, min_i, max_i, 32767, -32768, 1));
    // Nearly parallel far lines: parameters and midpoint saturate.
    send_pair(make_pair(max_i, min_i, 0, 32767, 32766, 0,
                        min_i, max_i, 0, 32766, 32767, 0));
    send_pair(make_pair(min_i, 0, max_i, 1, 32767, 0, max_i, 0, min_i, 0, 32767, 1));
    // Tiny directions and halfway rounding candidates.
    send_pair(make_pair(1, 0, 0, 1, 0, 0, 0, 1, 0, 0, 1, 0));
    send_pair(make_pair(3, -1, 2, 2, 1, 0, -1, 0, 1, 1, -2, 1));
    send_pair(make_pair(-1, -1, -1, -1, 1, 1, 1, 1, 1, 1, -1, 1));
    drain_pipeline();

    // Phases under several tolerances, the extremes among them.
    tol_plan = '{tol_t'(0), tol_t'(63), tol_t'($urandom_range(1, 62)),
                 tol_t'(20), TOL_SHIFT_RESET};
    foreach (tol_plan[ph]) begin
      write_tolerance(tol_plan[ph]);
      // The directed near-parallel pair again, now under this tolerance.
      send_pair(make_pair(max_i, min_i, 0, 32767, 32766, 0,
                          min_i, max_i, 0, 32766, 32767, 0));
      repeat (280) send_pair(random_pair());
      drain_pipeline();
    end

    if (fail_count == 0) begin
      $display("[line_pair_closest_midpoint_unit] OK");
    end else begin
      $display("[line_pair_closest_midpoint_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/lpcm_pkg.sv
hdl/lpcm_dly.sv
hdl/lpcm_mul.sv
hdl/lpcm_div.sv
hdl/line_pair_closest_midpoint_unit.sv
verif/lpcm_checker.sv
verif/tb_line_pair_closest_midpoint_unit.sv
